FILE: hw/rtl/frame_retransmit_buffer_macros.svh
// Assertion macros used by the frame retransmit buffer checker.
`ifndef FRAME_RETRANSMIT_BUFFER_MACROS_SVH
`define FRAME_RETRANSMIT_BUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame retransmit buffer check failed");

// Consequent must hold in the cycle after the antecedent.
`define FRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame retransmit buffer check failed");

`endif

FILE: hw/rtl/frb_pkg.sv
// Package: sizes, codes, sequencer states and RAM request types of the frame retransmit buffer.
`timescale 1ns / 1ps
package frb_pkg;

  // Slot count must be a power of two: the slot is the low bits of the sequence number.
  localparam int SLOTS       = 4096;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int FRAME_WORDS = 40;
  localparam int IDX_W       = 6;
  localparam int POS_W       = 7;
  localparam int WORD_W      = 32;
  localparam int SEQ_W       = 32;
  localparam int KIND_W      = 2;
  localparam int PAY_DEPTH   = SLOTS * FRAME_WORDS;
  localparam int PAY_AW      = $clog2(PAY_DEPTH);
  localparam int META_W      = SEQ_W + 1;

  localparam logic REQ_WORD = 1'b0;
  localparam logic REQ_RETX = 1'b1;

  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAIR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RETX   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_PAIR_LOOKUP,
    ST_PAIR_DECIDE,
    ST_READ,
    ST_LOAD
  } frb_state_t;

  // Slot tag memory: valid bit on top of the tag.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [META_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } meta_req_t;

  typedef struct packed {
    logic              we;
    logic [PAY_AW-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [PAY_AW-1:0] raddr;
  } pay_req_t;

endpackage

FILE: hw/rtl/frb_if.sv
// Interfaces: input request channel and output word channel.
`timescale 1ns / 1ps
interface frb_in_if;
  import frb_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SEQ_W-1:0]  seq;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] data_word;

  modport source (output valid, req_type, seq, word_index, data_word, input ready);
  modport sink   (input valid, req_type, seq, word_index, data_word, output ready);
  modport mon    (input valid, ready, req_type, seq, word_index, data_word);
endinterface

interface frb_out_if;
  import frb_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] pkt_kind;
  logic [SEQ_W-1:0]  pkt_seq;
  logic [POS_W-1:0]  word_pos;
  logic [WORD_W-1:0] out_word;
  logic              last_of_packet;

  modport source (output valid, pkt_kind, pkt_seq, word_pos, out_word, last_of_packet,
                  input ready);
  modport sink   (input valid, pkt_kind, pkt_seq, word_pos, out_word, last_of_packet,
                  output ready);
  modport mon    (input valid, ready, pkt_kind, pkt_seq, word_pos, out_word, last_of_packet);
endinterface

FILE: hw/rtl/frame_retransmit_buffer.sv
// Top level: frame retransmit buffer with slot tag memory and frame payload memory.
`timescale 1ns / 1ps
// Frame retransmit buffer. Payload words (req_type 0) are cached in a direct-mapped
// slot (seq modulo 4096, 40 words per slot) and passed straight through; the last
// word of an odd frame is followed by the previous frame's 40 words, or zeros when
// that frame is not cached. A retransmit request (req_type 1) replays the cached
// frame on a tag hit and gives nothing on a miss. After reset the block runs a
// pass clearing the slot valid bits and holds ready low meanwhile. Each request
// starts with a tag memory read and a decide step, which writes a payload word or
// drops one with an index of 40 or more. A retransmit hit streams the frame; an odd
// frame's last word first reads the previous frame's tag. The payload memory has one
// read port with registered data, so each streamed word takes a read step and then
// an output load step. One finished word waits in the output register.
module frame_retransmit_buffer
  import frb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  frb_in_if.sink    in_ch,
  frb_out_if.source out_ch
);

  meta_req_t         meta_req;
  pay_req_t          pay_req;
  logic [META_W-1:0] meta_rdata;
  logic [WORD_W-1:0] pay_rdata;

  frb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .meta_req   (meta_req),
    .meta_rdata (meta_rdata),
    .pay_req    (pay_req),
    .pay_rdata  (pay_rdata)
  );

  frb_ram #(
    .DEPTH (SLOTS),
    .AW    (SLOT_W),
    .DW    (META_W)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_req.we),
    .waddr (meta_req.waddr),
    .wdata (meta_req.wdata),
    .re    (meta_req.re),
    .raddr (meta_req.raddr),
    .rdata (meta_rdata)
  );

  frb_ram #(
    .DEPTH (PAY_DEPTH),
    .AW    (PAY_AW),
    .DW    (WORD_W)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_req.we),
    .waddr (pay_req.waddr),
    .wdata (pay_req.wdata),
    .re    (pay_req.re),
    .raddr (pay_req.raddr),
    .rdata (pay_rdata)
  );

endmodule

FILE: hw/rtl/frb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module frb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/frb_ctrl.sv
// Sequencer: slot lookup, shared address unit and tag compare, word streaming, output register.
`timescale 1ns / 1ps
module frb_ctrl
  import frb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  frb_in_if.sink            in_ch,
  frb_out_if.source         out_ch,
  output meta_req_t         meta_req,
  input  logic [META_W-1:0] meta_rdata,
  output pay_req_t          pay_req,
  input  logic [WORD_W-1:0] pay_rdata
);

  frb_state_t state, state_next;
  logic [SLOT_W-1:0] clr_cnt, clr_cnt_next;
  logic              out_valid, out_valid_next;

  logic              req, req_next;
  logic [SEQ_W-1:0]  seq, seq_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [WORD_W-1:0] data, data_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic              hit, hit_next;
  logic [KIND_W-1:0] kind, kind_next;

  logic [KIND_W-1:0] o_kind, o_kind_next;
  logic [SEQ_W-1:0]  o_seq, o_seq_next;
  logic [POS_W-1:0]  o_pos, o_pos_next;
  logic [WORD_W-1:0] o_word, o_word_next;
  logic              o_last, o_last_next;

  logic [SEQ_W-1:0]  pred_seq;
  logic [SEQ_W-1:0]  cmp_seq;
  logic              meta_v;
  logic              tag_eq;
  logic              tag_hit;
  logic [SLOT_W-1:0] addr_slot;
  logic [IDX_W-1:0]  addr_off;
  logic [PAY_AW-1:0] pay_addr;
  logic              out_free;
  logic              last_idx;
  logic              cnt_last;

  assign pred_seq = seq - SEQ_W'(1);
  assign cmp_seq  = (state == ST_PAIR_DECIDE) ? pred_seq : seq;
  assign meta_v   = meta_rdata[META_W-1];
  assign tag_eq   = (meta_rdata[SEQ_W-1:0] == cmp_seq);
  assign tag_hit  = meta_v && tag_eq;

  // Shared address unit: slot * FRAME_WORDS + offset.
  assign addr_slot = (state == ST_READ) ? slot : seq[SLOT_W-1:0];
  assign addr_off  = (state == ST_READ) ? cnt : idx;
  assign pay_addr  = PAY_AW'(addr_slot) * PAY_AW'(FRAME_WORDS) + PAY_AW'(addr_off);

  assign out_free = !out_valid || out_ch.ready;
  assign last_idx = (idx == IDX_W'(FRAME_WORDS - 1));
  assign cnt_last = (cnt == IDX_W'(FRAME_WORDS - 1));

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    out_valid_next = out_valid && !out_ch.ready;
    req_next       = req;
    seq_next       = seq;
    idx_next       = idx;
    data_next      = data;
    cnt_next       = cnt;
    slot_next      = slot;
    hit_next       = hit;
    kind_next      = kind;
    o_kind_next    = o_kind;
    o_seq_next     = o_seq;
    o_pos_next     = o_pos;
    o_word_next    = o_word;
    o_last_next    = o_last;
    meta_req       = '0;
    pay_req        = '0;
    in_ch.ready    = 1'b0;

    case (state)
      ST_CLEAR: begin
        meta_req.we    = 1'b1;
        meta_req.waddr = clr_cnt;
        clr_cnt_next   = clr_cnt + SLOT_W'(1);
        if (clr_cnt == SLOT_W'(SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready    = 1'b1;
        meta_req.re    = in_ch.valid;
        meta_req.raddr = in_ch.seq[SLOT_W-1:0];
        if (in_ch.valid) begin
          req_next   = in_ch.req_type;
          seq_next   = in_ch.seq;
          idx_next   = in_ch.word_index;
          data_next  = in_ch.data_word;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (req == REQ_RETX) begin
          if (tag_hit) begin
            slot_next  = seq[SLOT_W-1:0];
            hit_next   = 1'b1;
            kind_next  = KIND_RETX;
            cnt_next   = '0;
            state_next = ST_READ;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (idx >= IDX_W'(FRAME_WORDS)) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          // Store the word and update the slot; hold here while the output is full.
          meta_req.we    = 1'b1;
          meta_req.waddr = seq[SLOT_W-1:0];
          meta_req.wdata = {last_idx || (tag_hit && idx != '0), seq};
          pay_req.we     = 1'b1;
          pay_req.waddr  = pay_addr;
          pay_req.wdata  = data;
          out_valid_next = 1'b1;
          o_kind_next    = seq[0] ? KIND_PAIR : KIND_SINGLE;
          o_seq_next     = seq;
          o_pos_next     = POS_W'(idx);
          o_word_next    = data;
          o_last_next    = !seq[0] && last_idx;
          if (seq[0] && last_idx) begin
            kind_next  = KIND_PAIR;
            state_next = ST_PAIR_LOOKUP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAIR_LOOKUP: begin
        meta_req.re    = 1'b1;
        meta_req.raddr = pred_seq[SLOT_W-1:0];
        state_next     = ST_PAIR_DECIDE;
      end
      ST_PAIR_DECIDE: begin
        slot_next  = pred_seq[SLOT_W-1:0];
        hit_next   = tag_hit;
        cnt_next   = '0;
        state_next = ST_READ;
      end
      ST_READ: begin
        pay_req.re    = 1'b1;
        pay_req.raddr = pay_addr;
        state_next    = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          o_kind_next    = kind;
          o_seq_next     = seq;
          o_pos_next     = (kind == KIND_PAIR) ? POS_W'(FRAME_WORDS) + POS_W'(cnt)
                                               : POS_W'(cnt);
          o_word_next    = hit ? pay_rdata : '0;
          o_last_next    = cnt_last;
          cnt_next       = cnt + IDX_W'(1);
          state_next     = cnt_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req    <= req_next;
    seq    <= seq_next;
    idx    <= idx_next;
    data   <= data_next;
    cnt    <= cnt_next;
    slot   <= slot_next;
    hit    <= hit_next;
    kind   <= kind_next;
    o_kind <= o_kind_next;
    o_seq  <= o_seq_next;
    o_pos  <= o_pos_next;
    o_word <= o_word_next;
    o_last <= o_last_next;
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.pkt_kind       = o_kind;
  assign out_ch.pkt_seq        = o_seq;
  assign out_ch.word_pos       = o_pos;
  assign out_ch.out_word       = o_word;
  assign out_ch.last_of_packet = o_last;

endmodule

FILE: hw/rtl/frb_checker.sv
// Checker on the frame retransmit buffer ports, with its bind to the top level.
`timescale 1ns / 1ps
`include "frame_retransmit_buffer_macros.svh"
module frb_checker
  import frb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              word_valid,
  input logic              word_ready,
  input logic [KIND_W-1:0] word_kind,
  input logic [SEQ_W-1:0]  word_seq,
  input logic [POS_W-1:0]  word_pos,
  input logic [WORD_W-1:0] word_data,
  input logic              word_last
);

  logic                                     stall;
  logic                                     req_accept;
  logic [KIND_W+SEQ_W+POS_W+WORD_W:0]       word_bits;
  logic                                     last_pos_ok;
  logic                                     mid_stream;

  assign stall       = word_valid && !word_ready;
  assign req_accept  = req_valid && req_ready;
  assign word_bits   = {word_kind, word_seq, word_pos, word_data, word_last};
  assign last_pos_ok = (word_pos == POS_W'(FRAME_WORDS - 1)) ||
                       (word_pos == POS_W'(2 * FRAME_WORDS - 1));
  assign mid_stream  = word_valid && !word_last &&
                       (word_kind == KIND_RETX || word_pos >= POS_W'(FRAME_WORDS));

  // A stalled output word holds.
  `FRB_ASSERT_NEXT(a_out_hold, clk, rst, stall, word_valid && $stable(word_bits))

  // Ready drops after every accepted request.
  `FRB_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_accept, !req_ready)

  // Packets end on the last word of a frame half.
  `FRB_ASSERT_NOW(a_last_pos, clk, rst, word_valid && word_last, last_pos_ok)

  // No new request while a streamed packet is still unfinished.
  `FRB_ASSERT_NOW(a_no_accept_mid_stream, clk, rst, mid_stream, !req_ready)

endmodule

bind frame_retransmit_buffer frb_checker u_frb_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (in_ch.valid),
  .req_ready  (in_ch.ready),
  .word_valid (out_ch.valid),
  .word_ready (out_ch.ready),
  .word_kind  (out_ch.pkt_kind),
  .word_seq   (out_ch.pkt_seq),
  .word_pos   (out_ch.word_pos),
  .word_data  (out_ch.out_word),
  .word_last  (out_ch.last_of_packet)
);

FILE: test/tb_top.sv
// Self-checking testbench for the frame retransmit buffer.
`timescale 1ns / 1ps
module tb_top;
  import frb_pkg::*;

  typedef struct packed {
    logic              req_type;
    logic [SEQ_W-1:0]  seq;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] data_word;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] data;
    logic              last;
  } pkt_word_t;

  logic clk;
  logic rst;

  frb_in_if  in_ch ();
  frb_out_if out_ch ();

  frame_retransmit_buffer u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the frame cache
  logic [WORD_W-1:0] cached_words [int];
  logic [SEQ_W-1:0]  cached_tag   [SLOTS];
  bit                cached_valid [SLOTS];

  pkt_word_t        expected_words [$];
  logic [SEQ_W-1:0] recent_frames  [$];
  pkt_word_t        seen_word;
  pkt_word_t        due_word;
  int unsigned      mismatches;
  int unsigned      sent_items;
  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic pkt_word_t pkt_word(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
                                         int pos, logic [WORD_W-1:0] data, bit last);
    pkt_word_t w;
    w.kind = kind;
    w.seq  = seq;
    w.pos  = pos[POS_W-1:0];
    w.data = data;
    w.last = last;
    return w;
  endfunction

  function automatic bit frame_cached(logic [SEQ_W-1:0] seq, output int base);
    int slot;
    slot = int'(seq[SLOT_W-1:0]);
    base = slot * FRAME_WORDS;
    return cached_valid[slot] && cached_tag[slot] == seq;
  endfunction

  // Update the shadow cache and queue every packet word this request causes.
  function automatic void predict_packet_words(request_t r);
    int slot;
    int base;
    bit hit;
    slot = int'(r.seq[SLOT_W-1:0]);
    base = slot * FRAME_WORDS;
    if (r.req_type == REQ_RETX) begin
      if (frame_cached(r.seq, base)) begin
        for (int j = 0; j < FRAME_WORDS; j++)
          expected_words.push_back(pkt_word(KIND_RETX, r.seq, j, cached_words[base + j],
                                            j == FRAME_WORDS - 1));
      end
      return;
    end
    if (r.word_index >= FRAME_WORDS) return;
    if (r.word_index == 0 || cached_tag[slot] != r.seq) cached_valid[slot] = 1'b0;
    cached_tag[slot] = r.seq;
    cached_words[base + int'(r.word_index)] = r.data_word;
    if (r.word_index == FRAME_WORDS - 1) cached_valid[slot] = 1'b1;
    if (!r.seq[0]) begin
      expected_words.push_back(pkt_word(KIND_SINGLE, r.seq, int'(r.word_index), r.data_word,
                                        r.word_index == FRAME_WORDS - 1));
      return;
    end
    expected_words.push_back(pkt_word(KIND_PAIR, r.seq, int'(r.word_index), r.data_word, 1'b0));
    if (r.word_index == FRAME_WORDS - 1) begin
      hit = frame_cached(r.seq - 1, base);
      for (int j = 0; j < FRAME_WORDS; j++)
        expected_words.push_back(pkt_word(KIND_PAIR, r.seq, FRAME_WORDS + j,
                                          hit ? cached_words[base + j] : '0,
                                          j == FRAME_WORDS - 1));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen_word.kind = out_ch.pkt_kind;
      seen_word.seq  = out_ch.pkt_seq;
      seen_word.pos  = out_ch.word_pos;
      seen_word.data = out_ch.out_word;
      seen_word.last = out_ch.last_of_packet;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d seq %h pos %0d data %h last %0b",
                   seen_word.kind, seen_word.seq, seen_word.pos, seen_word.data,
                   seen_word.last);
      end else begin
        due_word = expected_words.pop_front();
        if (seen_word !== due_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %h %0d %h %0b, got %0d %h %0d %h %0b",
                     due_word.kind, due_word.seq, due_word.pos, due_word.data, due_word.last,
                     seen_word.kind, seen_word.seq, seen_word.pos, seen_word.data,
                     seen_word.last);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Call at a rising edge; returns at or after the edge that accepted the request.
  task automatic send_item(request_t r);
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= r.req_type;
    in_ch.seq        <= r.seq;
    in_ch.word_index <= r.word_index;
    in_ch.data_word  <= r.data_word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_packet_words(r);
    sent_items++;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop a last word that would mark a slot valid with entries never written.
  task automatic send_payload(logic [SEQ_W-1:0] seq, int idx, logic [WORD_W-1:0] data);
    request_t r;
    int base;
    base = int'(seq[SLOT_W-1:0]) * FRAME_WORDS;
    if (idx == FRAME_WORDS - 1)
      for (int j = 0; j < FRAME_WORDS - 1; j++)
        if (!cached_words.exists(base + j)) return;
    r.req_type   = REQ_WORD;
    r.seq        = seq;
    r.word_index = idx[IDX_W-1:0];
    r.data_word  = data;
    send_item(r);
  endtask

  task automatic send_retx(logic [SEQ_W-1:0] seq);
    request_t r;
    r.req_type   = REQ_RETX;
    r.seq        = seq;
    r.word_index = IDX_W'($urandom_range(63));
    r.data_word  = $urandom;
    send_item(r);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SEQ_W-1:0] pick_seq();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(15) + ($urandom_range(1) << SLOT_W);
      5, 6:          return $urandom;
      7:             return 32'hFFFF_FFFF - $urandom_range(3);
      default:       return recent_frames.size() > 0 ?
                            recent_frames[$urandom_range(recent_frames.size() - 1)] : $urandom;
    endcase
  endfunction

  // Damaged words are skipped or carry an aliasing sequence number (same slot, other tag).
  task automatic send_frame(logic [SEQ_W-1:0] seq, int damage_pct);
    for (int idx = 0; idx < FRAME_WORDS; idx++) begin
      if ($urandom_range(99) < damage_pct) begin
        if ($urandom_range(1)) send_payload(seq ^ (32'h1 << SLOT_W), idx, random_word());
      end else begin
        send_payload(seq, idx, random_word());
      end
    end
    recent_frames.push_back(seq);
    if (recent_frames.size() > 16) void'(recent_frames.pop_front());
  endtask

  task automatic test_paired_frame_hit();
    send_frame(32'hFFFF_FFFE, 0);
    send_frame(32'hFFFF_FFFF, 0);
  endtask

  // Another tag in the slot drops frame FFFF_FFFE, so the second half is zero fill.
  task automatic test_zero_fill();
    send_payload(32'h0000_0FFE, 7, random_word());
    send_payload(32'hFFFF_FFFF, FRAME_WORDS - 1, random_word());
  endtask

  task automatic test_retransmit();
    send_retx(32'hFFFF_FFFF);
    send_retx(32'hFFFF_FFFE);
    send_retx(32'd0);
    send_retx(32'h0000_0FFE);
  endtask

  task automatic test_ignored_and_invalidated();
    send_payload(32'hFFFF_FFFF, FRAME_WORDS, '1);
    send_payload($urandom, 63, random_word());
    send_payload($urandom, FRAME_WORDS + $urandom_range(63 - FRAME_WORDS), random_word());
    send_retx(32'hFFFF_FFFF);
    // A first word restarts the frame and drops the cached copy.
    send_payload(32'hFFFF_FFFF, 0, random_word());
    send_retx(32'hFFFF_FFFF);
  endtask

  task automatic test_random(int unsigned tx_pct, int unsigned rx_pct, int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    logic [SEQ_W-1:0] s;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = sent_items;
    while (sent_items - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        s = (recent_frames.size() > 0 && $urandom_range(1)) ?
            recent_frames[$urandom_range(recent_frames.size() - 1)] : pick_seq();
        if ($urandom_range(3) == 0) s = s ^ (32'h1 << SLOT_W);
        send_retx(s);
      end else if (pick < 80) begin
        send_payload(pick_seq(), $urandom_range(FRAME_WORDS - 1), random_word());
      end else begin
        send_payload($urandom, $urandom_range(FRAME_WORDS, 63), random_word());
      end
    end
    wait_all_results();
  endtask

  initial begin
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_WORD;
    in_ch.seq        = '0;
    in_ch.word_index = '0;
    in_ch.data_word  = '0;
    out_ch.ready     = 1'b0;
    mismatches       = 0;
    sent_items       = 0;
    tx_idle_pct      = 37;
    rx_idle_pct      = 47;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_paired_frame_hit();
    test_zero_fill();
    wait_all_results();
    test_retransmit();
    test_ignored_and_invalidated();

    test_random(47, 37, 10);
    test_random(0, 0, 10);

    // Let misses and ignored words retire, and catch stray output words.
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/frb_pkg.sv
hw/rtl/frb_if.sv
hw/rtl/frb_ram.sv
hw/rtl/frb_ctrl.sv
hw/rtl/frame_retransmit_buffer.sv
hw/rtl/frb_checker.sv
test/tb_top.sv
